// ===== rtl/dfpd_pkg.sv =====
package dfpd_pkg;

	// Sync bytes of the two frame formats
	localparam logic [7:0] SYNC_LONG_A  = 8'h55;
	localparam logic [7:0] SYNC_LONG_B  = 8'hAA;
	localparam logic [7:0] SYNC_SHORT_A = 8'hA5;
	localparam logic [7:0] SYNC_SHORT_B = 8'h5A;

	// Register map (word index) and reset value of the length limit
	localparam int unsigned     REG_IDX_W        = 1;
	localparam logic [REG_IDX_W-1:0] REG_IDX_LIMIT = 1'b0;
	localparam logic [15:0]     LIMIT_RESET      = 16'h0500;

	localparam int unsigned     DEFAULT_BUFFER_DEPTH = 512;
	localparam int unsigned     COUNT_W              = 9;

	// Hunt states; codes 12 to 15 are unused
	typedef enum logic [3:0] {
		HS_IDLE     = 4'd0,
		HS_GOT_55   = 4'd1,
		HS_GOT_A5   = 4'd2,
		HS_L_TARGET = 4'd3,
		HS_L_CMD    = 4'd4,
		HS_L_LENLO  = 4'd5,
		HS_L_LENHI  = 4'd6,
		HS_S_TARGET = 4'd7,
		HS_S_CMD    = 4'd8,
		HS_S_LEN    = 4'd9,
		HS_BODY     = 4'd10,
		HS_LAST_CRC = 4'd11
	} hunt_state_t;

	typedef struct packed {
		logic       command;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic               frame_end;
		logic               byte_kept;
		logic               flush_request;
		logic [COUNT_W-1:0] buffer_count;
	} result_t;

	// Start a new sync on a first sync byte, else stay idle
	function automatic hunt_state_t sync_start(input logic [7:0] b);
		hunt_state_t s;
		s = HS_IDLE;
		if (b == SYNC_LONG_A) s = HS_GOT_55;
		else if (b == SYNC_SHORT_A) s = HS_GOT_A5;
		return s;
	endfunction

endpackage

// ===== rtl/dual_format_packet_detector.sv =====
// Frame detector and receive-buffer occupancy tracker. Each transfer on the item channel is
// either a received byte (command 0) or a drain (command 1); each produces exactly one
// transfer on the result channel. The block takes one item per clock: the hunt state,
// length counter and occupancy update at the accepting edge and the result lands in a
// single output register, so item_ready is high whenever that register is empty or being
// taken in the same cycle. The long-format length limit is written over the APB port
// at word address 0 and should change only while no transfer is in flight.
module dual_format_packet_detector #(
	parameter int unsigned BUFFER_DEPTH = dfpd_pkg::DEFAULT_BUFFER_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	// item channel
	input  logic              item_valid,
	output logic              item_ready,
	input  dfpd_pkg::item_t   item,
	// result channel
	output logic              result_valid,
	input  logic              result_ready,
	output dfpd_pkg::result_t result,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import dfpd_pkg::*;

	localparam int unsigned OCC_W = $clog2(BUFFER_DEPTH);
	localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(BUFFER_DEPTH - 1);
	localparam logic [OCC_W-1:0] OCC_HALF = OCC_W'(BUFFER_DEPTH / 2);

	logic [15:0]            limit_q;
	hunt_state_t            state_q, state_d;
	logic [15:0]            rem_q, rem_d;
	logic [OCC_W-1:0]       occ_q, occ_d;
	logic                   flush_q, flush_d;
	logic                   end_d, kept_d;
	logic [OCC_W+COUNT_W-1:0] count_ext;
	logic [15:0]            long_len;
	logic                   take;
	logic                   cfg_wr;
	logic [REG_IDX_W-1:0]   reg_idx;
	result_t                result_d;

	// APB register access
	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		prdata = 32'd0;
		unique case (reg_idx)
			REG_IDX_LIMIT: prdata = {16'd0, limit_q};
			default:       prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr && reg_idx == REG_IDX_LIMIT) begin
			limit_q <= pwdata[15:0];
		end
	end

	// Handshake: take an item when the result register is free or draining
	assign item_ready = !result_valid || result_ready;
	assign take       = item_valid && item_ready;

	// Hunt next state and length counter
	assign long_len = {item.rx_byte, rem_q[7:0]};

	always_comb begin
		state_d = state_q;
		rem_d   = rem_q;
		unique case (state_q)
			HS_GOT_55: begin
				state_d = (item.rx_byte == SYNC_LONG_B) ? HS_L_TARGET : sync_start(item.rx_byte);
			end
			HS_GOT_A5: begin
				state_d = (item.rx_byte == SYNC_SHORT_B) ? HS_S_TARGET
					: sync_start(item.rx_byte);
			end
			HS_L_TARGET: state_d = HS_L_CMD;
			HS_L_CMD:    state_d = HS_L_LENLO;
			HS_S_TARGET: state_d = HS_S_CMD;
			HS_S_CMD:    state_d = HS_S_LEN;
			HS_L_LENLO: begin
				rem_d   = {8'd0, item.rx_byte};
				state_d = HS_L_LENHI;
			end
			HS_L_LENHI: begin
				rem_d   = long_len;
				state_d = (long_len < limit_q) ? HS_BODY : HS_IDLE;
			end
			HS_S_LEN: begin
				rem_d   = {8'd0, item.rx_byte};
				state_d = HS_BODY;
			end
			HS_BODY: begin
				if (rem_q != 16'd0) rem_d = rem_q - 16'd1;
				else state_d = HS_LAST_CRC;
			end
			HS_LAST_CRC: state_d = HS_IDLE;
			default:     state_d = sync_start(item.rx_byte);
		endcase
	end

	// Hunt outputs: the final CRC byte closes a frame
	always_comb begin
		end_d = 1'b0;
		unique case (state_q)
			HS_LAST_CRC: end_d = 1'b1;
			default:     end_d = 1'b0;
		endcase
	end

	// Occupancy, flush flag and result fields
	always_comb begin
		occ_d    = occ_q;
		flush_d  = flush_q;
		kept_d   = 1'b0;
		result_d = '0;
		if (item.command) begin
			occ_d   = '0;
			flush_d = 1'b0;
		end else begin
			if (occ_q < OCC_FULL) begin
				occ_d  = occ_q + 1'b1;
				kept_d = 1'b1;
			end
			if (end_d || occ_d > OCC_HALF) flush_d = 1'b1;
		end
		count_ext                = {{COUNT_W{1'b0}}, (item.command ? occ_q : occ_d)};
		result_d.frame_end       = end_d && !item.command;
		result_d.byte_kept       = kept_d;
		result_d.flush_request   = flush_d;
		result_d.buffer_count    = count_ext[COUNT_W-1:0];
	end

	// Advance state on each accepted item; a drain holds the hunt
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= HS_IDLE;
			rem_q   <= 16'd0;
			occ_q   <= '0;
			flush_q <= 1'b0;
		end else if (take) begin
			occ_q   <= occ_d;
			flush_q <= flush_d;
			if (!item.command) begin
				state_q <= state_d;
				rem_q   <= rem_d;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (take) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result <= result_d;
		end
	end

`ifndef SYNTH
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_FULL)
		else $error("occupancy above buffer capacity");

	a_drain_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && item.command) |=> (occ_q == '0 && !flush_q))
		else $error("drain did not clear occupancy and flush flag");

	a_end_flushes: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.frame_end) |-> result.flush_request)
		else $error("frame end without flush request");

	a_body_to_crc: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !item.command && state_q == HS_BODY && rem_q == 16'd0)
		|=> state_q == HS_LAST_CRC)
		else $error("body end did not reach final CRC byte");
`endif

endmodule
